// ----- src/u8u16_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

	localparam int U8U16_QUEUE_DEPTH = 4;

	localparam logic [1:0] KIND_UNIT  = 2'd0;
	localparam logic [1:0] KIND_ERROR = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	localparam logic [7:0] LEAD_E0 = 8'hE0;
	localparam logic [7:0] LEAD_ED = 8'hED;
	localparam logic [7:0] LEAD_F0 = 8'hF0;
	localparam logic [7:0] LEAD_F4 = 8'hF4;

	localparam logic [7:0] ASCII_MAX  = 8'h7F;
	localparam logic [7:0] LEAD2_MIN  = 8'hC2;
	localparam logic [7:0] LEAD2_MAX  = 8'hDF;
	localparam logic [7:0] LEAD3_MAX  = 8'hEF;
	localparam logic [7:0] CONT_MIN   = 8'h80;
	localparam logic [7:0] CONT_MAX   = 8'hBF;
	localparam logic [7:0] CONT_E0_LO = 8'hA0;
	localparam logic [7:0] CONT_ED_HI = 8'h9F;
	localparam logic [7:0] CONT_F0_LO = 8'h90;
	localparam logic [7:0] CONT_F4_HI = 8'h8F;

	localparam logic [20:0] BMP_MAX     = 21'h00FFFF;
	localparam logic [20:0] SUPP_BASE   = 21'h010000;
	localparam logic [15:0] HIGH_SURR   = 16'hD800;
	localparam logic [15:0] LOW_SURR    = 16'hDC00;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] code_unit;
		logic        final_item;
	} out_word_t;

	// One byte's worth of results: units first, then error, then end marker.
	typedef struct packed {
		logic [1:0]  unit_cnt;
		logic [15:0] unit0;
		logic [15:0] unit1;
		logic        err;
		logic        fin;
	} job_t;

endpackage

`default_nettype wire

// ----- src/u8u16_front.sv -----
// Front end: byte validation, code point assembly and job building.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  take,
	input  u8u16_pkg::in_word_t  word,
	output logic                 job_valid,
	output u8u16_pkg::job_t      job
);
	import u8u16_pkg::*;

	logic [7:0]  lead_q, lead_n;
	logic [1:0]  need_q, need_n;
	logic [1:0]  seen_q, seen_n;
	logic [20:0] acc_q, acc_n;
	logic        disc_q, disc_n;

	logic        emit_cp;
	logic [20:0] cp;
	logic        err;
	logic [7:0]  lo, hi;
	logic [7:0]  b;
	logic [19:0] off;

	assign b = word.byte_value;

	always_comb begin
		lead_n  = lead_q;
		need_n  = need_q;
		seen_n  = seen_q;
		acc_n   = acc_q;
		disc_n  = disc_q;
		emit_cp = 1'b0;
		cp      = '0;
		err     = 1'b0;
		lo      = CONT_MIN;
		hi      = CONT_MAX;
		if (!disc_q) begin
			if (need_q == 2'd0) begin
				if (b <= ASCII_MAX) begin
					emit_cp = 1'b1;
					cp      = {13'd0, b};
				end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
					lead_n = b;
					need_n = 2'd1;
					seen_n = 2'd0;
					acc_n  = {16'd0, b[4:0]};
				end else if (b >= LEAD_E0 && b <= LEAD3_MAX) begin
					lead_n = b;
					need_n = 2'd2;
					seen_n = 2'd0;
					acc_n  = {17'd0, b[3:0]};
				end else if (b >= LEAD_F0 && b <= LEAD_F4) begin
					lead_n = b;
					need_n = 2'd3;
					seen_n = 2'd0;
					acc_n  = {18'd0, b[2:0]};
				end else begin
					err = 1'b1;
				end
			end else begin
				// tighten the first continuation after leads that bound the range
				if (seen_q == 2'd0) begin
					if (lead_q == LEAD_E0) lo = CONT_E0_LO;
					else if (lead_q == LEAD_ED) hi = CONT_ED_HI;
					else if (lead_q == LEAD_F0) lo = CONT_F0_LO;
					else if (lead_q == LEAD_F4) hi = CONT_F4_HI;
				end
				if (b < lo || b > hi) begin
					err = 1'b1;
				end else begin
					acc_n  = {acc_q[14:0], b[5:0]};
					seen_n = seen_q + 2'd1;
					if (seen_n >= need_q) begin
						emit_cp = 1'b1;
						cp      = acc_n;
						lead_n  = '0;
						need_n  = '0;
						seen_n  = '0;
						acc_n   = '0;
					end
				end
			end
		end
		if (err) begin
			disc_n = 1'b1;
			lead_n = '0;
			need_n = '0;
			seen_n = '0;
			acc_n  = '0;
		end
		// a string cut short inside a sequence is an error before the end marker
		if (word.last_byte) begin
			if (!disc_n && need_n != 2'd0) err = 1'b1;
			disc_n = 1'b0;
			lead_n = '0;
			need_n = '0;
			seen_n = '0;
			acc_n  = '0;
		end
	end

	assign off = cp[19:0] - SUPP_BASE[19:0];

	always_comb begin
		job.err  = err;
		job.fin  = word.last_byte;
		job.unit_cnt = 2'd0;
		job.unit0 = cp[15:0];
		job.unit1 = '0;
		if (emit_cp) begin
			if (cp > BMP_MAX) begin
				job.unit_cnt = 2'd2;
				job.unit0    = HIGH_SURR + {6'd0, off[19:10]};
				job.unit1    = LOW_SURR + {6'd0, cp[9:0]};
			end else begin
				job.unit_cnt = 2'd1;
			end
		end
	end

	assign job_valid = take && (job.unit_cnt != 2'd0 || job.err || job.fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
			need_q <= '0;
			seen_q <= '0;
			acc_q  <= '0;
			disc_q <= 1'b0;
		end else if (take) begin
			lead_q <= lead_n;
			need_q <= need_n;
			seen_q <= seen_n;
			acc_q  <= acc_n;
			disc_q <= disc_n;
		end
	end

endmodule

`default_nettype wire

// ----- src/u8u16_fifo.sv -----
// Job queue between the front end and the result sequencer.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_fifo #(
	parameter int DEPTH = u8u16_pkg::U8U16_QUEUE_DEPTH
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  u8u16_pkg::job_t  push_job,
	input  wire              pop,
	output u8u16_pkg::job_t  head_job,
	output logic             empty,
	output logic             full
);
	import u8u16_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(DEPTH));
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop) rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

// ----- src/u8u16_back.sv -----
// Back end: walks each job's results into the output register.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   head_valid,
	input  u8u16_pkg::job_t       head_job,
	output logic                  pop,
	output logic                  out_valid,
	output u8u16_pkg::out_word_t  out_word,
	input  wire                   out_stall
);
	import u8u16_pkg::*;

	logic [1:0] idx_q;
	logic [2:0] total;
	logic       load;
	logic       last_res;
	out_word_t  res;
	logic       out_valid_q;
	out_word_t  out_q;

	assign total    = 3'(head_job.unit_cnt) + 3'(head_job.err) + 3'(head_job.fin);
	assign last_res = (3'(idx_q) + 3'd1 >= total);
	assign load     = !out_valid_q || !out_stall;
	assign pop      = load && head_valid && last_res;

	always_comb begin
		res.kind       = KIND_END;
		res.code_unit  = '0;
		res.final_item = 1'b1;
		if (3'(idx_q) < 3'(head_job.unit_cnt)) begin
			res.kind       = KIND_UNIT;
			res.code_unit  = (idx_q == 2'd0) ? head_job.unit0 : head_job.unit1;
			res.final_item = 1'b0;
		end else if (head_job.err && idx_q == head_job.unit_cnt) begin
			res.kind       = KIND_ERROR;
			res.final_item = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) idx_q <= last_res ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

`default_nettype wire

// ----- src/utf8_to_utf16_transcoder.sv -----
// A completed UTF-16 word is registered in the job queue, then in the output register.
// Throughput: one byte per cycle while each byte yields at most one result and the
// output is not stalled; the sequencer sends one result per cycle unless stalled, and jobs
// with a surrogate pair or an end marker plus another result wait in the 4-entry job queue.
// Reset: arst_n clears the decoder state, the queue and the output valid at once.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_transcoder #(
	parameter int QUEUE_DEPTH = u8u16_pkg::U8U16_QUEUE_DEPTH
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   utf8_valid,
	output logic                  utf8_stall,
	input  u8u16_pkg::in_word_t   utf8_word,
	output logic                  utf16_valid,
	input  wire                   utf16_stall,
	output u8u16_pkg::out_word_t  utf16_word
);
	import u8u16_pkg::*;

	logic take;
	logic job_valid;
	job_t job;
	job_t head_job;
	logic q_empty, q_full;
	logic pop;

	assign utf8_stall = q_full;
	assign take       = utf8_valid && !q_full;

	u8u16_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.word      (utf8_word),
		.job_valid (job_valid),
		.job       (job)
	);

	u8u16_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_valid),
		.push_job (job),
		.pop      (pop),
		.head_job (head_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	u8u16_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (utf16_valid),
		.out_word   (utf16_word),
		.out_stall  (utf16_stall)
	);

	a_final_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		utf16_valid |-> (utf16_word.final_item == (utf16_word.kind == KIND_END)))
		else $error("final_item does not match end-of-string kind");

	a_unit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		utf16_valid && utf16_word.kind != KIND_UNIT |-> utf16_word.code_unit == 16'd0)
		else $error("code_unit nonzero on a non-unit word");

	a_full_drains: assert property (@(posedge clk) disable iff (!arst_n)
		utf8_stall && !utf16_valid |=> utf16_valid)
		else $error("full queue did not feed the output register");

endmodule

`default_nettype wire

// ----- tb/tb_utf8_to_utf16_transcoder.sv -----
// Self-checking testbench for the UTF-8 to UTF-16 transcoder: directed and random strings.
`timescale 1ns / 1ps

module tb_utf8_to_utf16_transcoder;

	import u8u16_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BYTES = 232;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;

	// Decodes the byte stream the way the block should and checks the words it sends.
	class utf16_scoreboard;
		out_word_t   expected_words[$];
		logic [7:0]  lead;
		logic [1:0]  need;
		logic [1:0]  seen;
		logic [20:0] cp_acc;
		logic        skipping;
		int          fails;
		int          bytes_in;
		int          units_seen;
		int          errors_seen;
		int          ends_seen;

		function new();
			clear_seq();
			skipping = 1'b0;
			fails = 0;
			bytes_in = 0;
			units_seen = 0;
			errors_seen = 0;
			ends_seen = 0;
		endfunction

		function void clear_seq();
			lead = 8'h00;
			need = 2'd0;
			seen = 2'd0;
			cp_acc = 21'd0;
		endfunction

		function void push(logic [1:0] kind, logic [15:0] unit, logic fin);
			out_word_t w;
			w.kind = kind;
			w.code_unit = unit;
			w.final_item = fin;
			expected_words.push_back(w);
		endfunction

		function void push_code_point(logic [20:0] cp);
			logic [20:0] off;
			if (cp <= BMP_MAX) begin
				push(KIND_UNIT, cp[15:0], 1'b0);
			end else begin
				off = cp - SUPP_BASE;
				push(KIND_UNIT, HIGH_SURR + {6'd0, off[19:10]}, 1'b0);
				push(KIND_UNIT, LOW_SURR + {6'd0, cp[9:0]}, 1'b0);
			end
		endfunction

		function void fault();
			push(KIND_ERROR, 16'h0000, 1'b0);
			skipping = 1'b1;
			clear_seq();
		endfunction

		function void note_byte(in_word_t w);
			logic [7:0]  b;
			logic [7:0]  lo;
			logic [7:0]  hi;
			logic [20:0] cp;
			b = w.byte_value;
			bytes_in++;
			if (!skipping) begin
				if (need == 2'd0) begin
					if (b <= ASCII_MAX) begin
						push_code_point({13'd0, b});
					end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
						lead = b;
						need = 2'd1;
						cp_acc = {16'd0, b[4:0]};
					end else if (b >= LEAD_E0 && b <= LEAD3_MAX) begin
						lead = b;
						need = 2'd2;
						cp_acc = {17'd0, b[3:0]};
					end else if (b >= LEAD_F0 && b <= LEAD_F4) begin
						lead = b;
						need = 2'd3;
						cp_acc = {18'd0, b[2:0]};
					end else begin
						fault();
					end
				end else begin
					lo = CONT_MIN;
					hi = CONT_MAX;
					// narrow the first continuation to reject overlongs, surrogates and > U+10FFFF
					if (seen == 2'd0) begin
						case (lead)
							LEAD_E0: lo = CONT_E0_LO;
							LEAD_ED: hi = CONT_ED_HI;
							LEAD_F0: lo = CONT_F0_LO;
							LEAD_F4: hi = CONT_F4_HI;
							default: ;
						endcase
					end
					if (b < lo || b > hi) begin
						fault();
					end else begin
						cp_acc = {cp_acc[14:0], b[5:0]};
						seen = seen + 2'd1;
						if (seen >= need) begin
							cp = cp_acc;
							clear_seq();
							push_code_point(cp);
						end
					end
				end
			end
			if (w.last_byte) begin
				// an open sequence at the end of the string is truncated
				if (!skipping && need != 2'd0)
					fault();
				push(KIND_END, 16'h0000, 1'b1);
				clear_seq();
				skipping = 1'b0;
			end
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (expected_words.size() == 0) begin
				$error("unexpected word: kind %0d code_unit %h final_item %0d",
					got.kind, got.code_unit, got.final_item);
				fails++;
				return;
			end
			want = expected_words.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, got.kind);
				fails++;
			end
			if (got.code_unit !== want.code_unit) begin
				$error("code_unit: expected %h, actual %h", want.code_unit, got.code_unit);
				fails++;
			end
			if (got.final_item !== want.final_item) begin
				$error("final_item: expected %0d, actual %0d", want.final_item, got.final_item);
				fails++;
			end
			case (want.kind)
				KIND_UNIT:  units_seen++;
				KIND_ERROR: errors_seen++;
				default:    ends_seen++;
			endcase
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      utf8_valid = 1'b0;
	logic      utf8_stall;
	in_word_t  utf8_word = '0;
	logic      utf16_valid;
	logic      utf16_stall = 1'b0;
	out_word_t utf16_word;

	utf16_scoreboard sb;
	rx_mode_t        rx_mode = RX_LIGHT;
	int              stall_run = 0;
	int              cycle_count = 0;
	bit              gap_mode = 1'b1;
	int              burst_left = 0;
	int              strings_sent = 0;

	utf8_to_utf16_transcoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.utf8_valid  (utf8_valid),
		.utf8_stall  (utf8_stall),
		.utf8_word   (utf8_word),
		.utf16_valid (utf16_valid),
		.utf16_stall (utf16_stall),
		.utf16_word  (utf16_word)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d words still expected", cycle_count, sb.pending());
		$display("tb_utf8_to_utf16_transcoder: done, errors");
		$finish;
	end

	// Receiver stalls in runs whose length and density follow rx_mode.
	always @(posedge clk) begin
		if (stall_run != 0) begin
			stall_run <= stall_run - 1;
		end else begin
			case (rx_mode)
				RX_FREE: begin
					utf16_stall <= 1'b0;
					stall_run <= 4;
				end
				RX_LIGHT: begin
					utf16_stall <= ($urandom_range(0, 3) == 0);
					stall_run <= $urandom_range(0, 2);
				end
				default: begin
					utf16_stall <= ($urandom_range(0, 1) == 0);
					stall_run <= $urandom_range(0, 7);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (utf8_valid && !utf8_stall)
				sb.note_byte(utf8_word);
			if (utf16_valid && !utf16_stall)
				sb.check_word(utf16_word);
		end
	end

	// Hold the word until accepted; between bursts, in gap mode, drop valid for a random gap.
	task automatic send_byte(input logic [7:0] b, input logic lst);
		if (burst_left == 0) begin
			if (gap_mode) begin
				utf8_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		utf8_valid <= 1'b1;
		utf8_word.byte_value <= b;
		utf8_word.last_byte <= lst;
		@(posedge clk);
		while (utf8_stall) @(posedge clk);
	endtask

	task automatic send_string(input logic [7:0] str[$]);
		foreach (str[i])
			send_byte(str[i], i == str.size() - 1);
		strings_sent++;
	endtask

	function automatic void append_random_cp(ref logic [7:0] q[$]);
		logic [20:0] cp_corners[10] = '{21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800,
			21'hD7FF, 21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF};
		logic [7:0]  near_leads[7] = '{8'hC0, 8'hC1, 8'hE0, 8'hED, 8'hF0, 8'hF4, 8'hF5};
		logic [20:0] cp;
		logic [7:0]  seq[$];
		logic [7:0]  ld;
		int          n_cont;
		case ($urandom_range(0, 9))
			0, 1, 2: cp = 21'($urandom_range(0, 'h7F));
			3, 4:    cp = 21'($urandom_range('h80, 'h7FF));
			5, 6: begin
				cp = 21'($urandom_range('h800, 'hFFFF));
				if (cp >= 21'hD800 && cp <= 21'hDFFF)
					cp = cp - 21'h1000;
			end
			7, 8:    cp = 21'($urandom_range('h10000, 'h10FFFF));
			default: cp = cp_corners[$urandom_range(0, 9)];
		endcase
		if (cp < 21'h80) begin
			seq.push_back(cp[7:0]);
		end else if (cp < 21'h800) begin
			seq.push_back({3'b110, cp[10:6]});
			seq.push_back({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			seq.push_back({4'b1110, cp[15:12]});
			seq.push_back({2'b10, cp[11:6]});
			seq.push_back({2'b10, cp[5:0]});
		end else begin
			seq.push_back({5'b11110, cp[20:18]});
			seq.push_back({2'b10, cp[17:12]});
			seq.push_back({2'b10, cp[11:6]});
			seq.push_back({2'b10, cp[5:0]});
		end
		// damage a few sequences: bad byte, cut short (a lone continuation if one byte), stray byte, near-miss lead
		case ($urandom_range(0, 11))
			0: seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
			1: begin
				if (seq.size() > 1)
					void'(seq.pop_back());
				else
					seq[0] = 8'($urandom_range(8'h80, 8'hBF));
			end
			2: seq.push_front(8'($urandom_range(0, 255)));
			3: begin
				ld = near_leads[$urandom_range(0, 6)];
				n_cont = (ld >= 8'hF0) ? 3 : (ld >= 8'hE0) ? 2 : 1;
				seq.delete();
				seq.push_back(ld);
				repeat (n_cont) seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end
			default: ;
		endcase
		foreach (seq[i])
			q.push_back(seq[i]);
	endfunction

	initial begin
		logic [7:0] str[$];
		int         random_bytes;
		sb = new();
		random_bytes = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest of each length, then an ASCII end
		str = {8'h00, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hF0, 8'h90, 8'h80, 8'h80, 8'h7F};
		send_string(str);
		// U+10FFFF on the last byte: surrogate pair plus end marker
		str = {8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_string(str);
		// encoded surrogate, then bytes that must be dropped
		str = {8'hED, 8'hA0, 8'h41, 8'hFF};
		send_string(str);
		// overlong three-byte form caught on the last byte
		str = {8'hDF, 8'hBF, 8'hE0, 8'h9F};
		send_string(str);
		// lone continuation byte as the whole string
		str = {8'h80};
		send_string(str);
		// sequence cut short by the end of the string
		str = {8'hE2, 8'h82};
		send_string(str);
		// failed continuation that would be valid ASCII is itself dropped
		str = {8'hC2, 8'h41};
		send_string(str);

		while (random_bytes < RANDOM_BYTES) begin
			if (strings_sent % 4 == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 2));
				gap_mode = ($urandom_range(0, 3) != 0);
			end
			str.delete();
			repeat ($urandom_range(1, 6)) append_random_cp(str);
			send_string(str);
			random_bytes += str.size();
		end
		utf8_valid <= 1'b0;

		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d strings, %0d bytes, with sender gaps and receiver stalls",
			strings_sent, sb.bytes_in);
		$display("checked %0d UTF-16 units, %0d error words, %0d string ends",
			sb.units_seen, sb.errors_seen, sb.ends_seen);
		if (sb.fails == 0)
			$display("tb_utf8_to_utf16_transcoder: done, clean");
		else
			$display("tb_utf8_to_utf16_transcoder: done, errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/u8u16_pkg.sv
src/u8u16_front.sv
src/u8u16_fifo.sv
src/u8u16_back.sv
src/utf8_to_utf16_transcoder.sv
tb/tb_utf8_to_utf16_transcoder.sv
